### rtl/rmsl_pkg.sv
`default_nettype none
package rmsl_pkg;

	localparam int MAX_SAMPLES_DEF = 65536;

	localparam int SAMPLE_W  = 16;
	localparam int OUT_W     = 17;
	// square of a 16-bit magnitude, up to 2^30
	localparam int SQ_W      = 31;
	// quotient 4*sum/count stays at or below 2^32; padded to an even width for the root
	localparam int RAD_W     = 34;
	localparam int ROOT_W    = RAD_W / 2;
	localparam int SREM_W    = ROOT_W + 2;
	localparam int LEVEL_MAX = 65536;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADD,
		ST_DIV,
		ST_SQRT,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load_sq;
		logic add;
		logic shift;
		logic clear;
	} acc_ctrl_t;

endpackage
`default_nettype wire

### rtl/rmsl_sub.sv
`default_nettype none
module rmsl_sub #(
	parameter int W = 19
) (
	input  wire logic [W-1:0] a,
	input  wire logic [W-1:0] b,
	output logic      [W-1:0] diff,
	output logic              ge
);

	logic [W:0] full;

	// borrow out of the wide subtract doubles as the compare
	assign full = {1'b0, a} - {1'b0, b};
	assign diff = full[W-1:0];
	assign ge   = ~full[W];

endmodule
`default_nettype wire

### rtl/rmsl_acc.sv
`default_nettype none
module rmsl_acc #(
	parameter int SUM_W = 47
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire rmsl_pkg::acc_ctrl_t                   ctrl,
	input  wire logic signed [rmsl_pkg::SAMPLE_W-1:0]  sample,
	output logic                                       sum_msb
);

	import rmsl_pkg::*;

	logic [SAMPLE_W-1:0]   raw;
	logic [SAMPLE_W-1:0]   mag;
	logic [2*SAMPLE_W-1:0] sq_full;
	logic [SQ_W-1:0]       sq_q;
	logic [SUM_W-1:0]      sum_q;

	assign raw     = sample;
	// -32768 maps to 0x8000, which reads as 32768 unsigned
	assign mag     = raw[SAMPLE_W-1] ? (~raw + 1'b1) : raw;
	assign sq_full = mag * mag;
	assign sum_msb = sum_q[SUM_W-1];

	always_ff @(posedge clk) begin
		if (ctrl.load_sq) begin
			sq_q <= sq_full[SQ_W-1:0];
		end
	end

	// the divider consumes the sum MSB first, leaving it zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (ctrl.clear) begin
			sum_q <= '0;
		end else if (ctrl.add) begin
			sum_q <= sum_q + SUM_W'(sq_q);
		end else if (ctrl.shift) begin
			sum_q <= {sum_q[SUM_W-2:0], 1'b0};
		end
	end

endmodule
`default_nettype wire

### rtl/block_rms_level.sv
// Non-last item: accepted in idle, squared on entry, added in the next cycle; a new item is taken
// only once the add is done. Last item: add, then a restoring divide of 4*sum by the count
// (SUM_W+2 steps), then a digit-by-digit square root (17 steps), all on one shared
// compare-subtract unit. The result register frees the input as soon as it is loaded; a held
// result stalls only the next block end. Reset (arst_n low) clears sum, count, overflow flag,
// sequencer and result valid; the result registers themselves are not reset.
`default_nettype none
module block_rms_level #(
	parameter int MAX_SAMPLES = rmsl_pkg::MAX_SAMPLES_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	output logic                                      in_ready,
	input  wire logic signed [rmsl_pkg::SAMPLE_W-1:0] sample,
	input  wire logic                                 last,
	output logic                                      out_valid,
	input  wire logic                                 out_ready,
	output logic             [rmsl_pkg::OUT_W-1:0]    rms_level,
	output logic             [rmsl_pkg::OUT_W-1:0]    block_samples,
	output logic                                      too_long
);

	import rmsl_pkg::*;

	localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
	localparam int SUM_W  = SQ_W - 1 + CNT_W;
	localparam int DIV_W  = SUM_W + 2;
	localparam int STEP_W = $clog2(DIV_W);
	localparam int SUB_W  = (CNT_W + 1 > SREM_W) ? CNT_W + 1 : SREM_W;
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SAMPLES);

	state_t             state_q, state_d;
	logic [CNT_W-1:0]   count_q;
	logic               ovf_q;
	logic [STEP_W-1:0]  step_q;
	logic               last_q;
	logic               take_q;
	logic [SUB_W-1:0]   rem_q;
	logic [RAD_W-1:0]   wq_q;
	logic [ROOT_W-1:0]  root_q;
	logic               out_valid_q;
	logic [OUT_W-1:0]   rms_q;
	logic [OUT_W-1:0]   bs_q;
	logic               tl_q;

	logic               full;
	logic               accept;
	logic               out_load;
	logic               sum_msb;
	logic [SUB_W-1:0]   sub_a;
	logic [SUB_W-1:0]   sub_b;
	logic [SUB_W-1:0]   sub_diff;
	logic               sub_ge;
	acc_ctrl_t          acc_ctrl;

	assign full          = (count_q == MAX_CNT);
	assign accept        = in_valid && in_ready;
	assign out_valid     = out_valid_q;
	assign rms_level     = rms_q;
	assign block_samples = bs_q;
	assign too_long      = tl_q;

	rmsl_acc #(
		.SUM_W (SUM_W)
	) u_acc (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (acc_ctrl),
		.sample  (sample),
		.sum_msb (sum_msb)
	);

	rmsl_sub #(
		.W (SUB_W)
	) u_sub (
		.a    (sub_a),
		.b    (sub_b),
		.diff (sub_diff),
		.ge   (sub_ge)
	);

	// operand select for the shared unit: root trial or divisor compare
	always_comb begin
		if (state_q == ST_SQRT) begin
			sub_a = SUB_W'({rem_q[SREM_W-3:0], wq_q[RAD_W-1 -: 2]});
			sub_b = SUB_W'({root_q, 2'b01});
		end else begin
			sub_a = SUB_W'({rem_q[CNT_W-1:0], sum_msb});
			sub_b = SUB_W'(count_q);
		end
	end

	always_comb begin
		state_d          = state_q;
		in_ready         = 1'b0;
		out_load         = 1'b0;
		acc_ctrl.load_sq = 1'b0;
		acc_ctrl.add     = 1'b0;
		acc_ctrl.shift   = 1'b0;
		acc_ctrl.clear   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready         = 1'b1;
				acc_ctrl.load_sq = in_valid && !full;
				if (in_valid) begin
					state_d = ST_ADD;
				end
			end
			ST_ADD: begin
				acc_ctrl.add = take_q;
				state_d      = last_q ? ST_DIV : ST_IDLE;
			end
			ST_DIV: begin
				acc_ctrl.shift = 1'b1;
				if (step_q == '0) begin
					state_d = ST_SQRT;
				end
			end
			ST_SQRT: begin
				if (step_q == '0) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				out_load = !out_valid_q || out_ready;
				acc_ctrl.clear = out_load;
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			ovf_q       <= 1'b0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				if (full) begin
					ovf_q <= 1'b1;
				end else begin
					count_q <= count_q + 1'b1;
				end
			end
			if (out_load) begin
				count_q <= '0;
				ovf_q   <= 1'b0;
			end
			case (state_q)
				ST_ADD: begin
					step_q <= STEP_W'(DIV_W - 1);
				end
				ST_DIV: begin
					step_q <= (step_q == '0) ? STEP_W'(ROOT_W - 1) : step_q - 1'b1;
				end
				ST_SQRT: begin
					step_q <= step_q - 1'b1;
				end
				default: begin
					step_q <= step_q;
				end
			endcase
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			last_q <= last;
			take_q <= !full;
		end
		case (state_q)
			ST_ADD: begin
				rem_q <= '0;
			end
			ST_DIV: begin
				// quotient bits shift in; its top bits are known zero
				wq_q <= {wq_q[RAD_W-2:0], sub_ge};
				if (step_q == '0) begin
					rem_q  <= '0;
					root_q <= '0;
				end else if (sub_ge) begin
					rem_q <= SUB_W'(sub_diff[CNT_W-1:0]);
				end else begin
					rem_q <= SUB_W'(sub_a[CNT_W-1:0]);
				end
			end
			ST_SQRT: begin
				wq_q   <= {wq_q[RAD_W-3:0], 2'b00};
				root_q <= {root_q[ROOT_W-2:0], sub_ge};
				if (sub_ge) begin
					rem_q <= SUB_W'(sub_diff[SREM_W-1:0]);
				end else begin
					rem_q <= SUB_W'(sub_a[SREM_W-1:0]);
				end
			end
			default: begin
				rem_q <= rem_q;
			end
		endcase
		if (out_load) begin
			rms_q <= OUT_W'(root_q);
			bs_q  <= OUT_W'(count_q);
			tl_q  <= ovf_q;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= MAX_CNT)
		else $error("sample count beyond limit");

	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> full)
		else $error("overflow flag set with count not full");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (count_q != '0))
		else $error("divide with zero count");

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (rms_q <= OUT_W'(LEVEL_MAX)))
		else $error("rms level above full scale");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (out_valid_q && (state_q == ST_IDLE)))
		else $error("result load did not raise valid");

endmodule
`default_nettype wire

### verif/block_rms_level_tb.sv
`timescale 1ns / 100ps
module block_rms_level_tb;
	import rmsl_pkg::*;

	localparam int MAX_SAMPLES = MAX_SAMPLES_DEF;
	localparam int RANDOM_ITEMS = 1400;
	// items from here on go out with no idling on either side
	localparam int CALM_FROM = 1250;
	localparam int TAIL_CYCLES = 150;

	typedef struct {
		logic signed [SAMPLE_W-1:0] value;
		logic                       closes;
		bit                         drain_first;
		bit                         steady;
	} audio_item_t;

	typedef struct {
		logic [OUT_W-1:0] level;
		logic [OUT_W-1:0] count;
		logic             clipped;
	} rms_result_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       in_valid = 1'b0;
	logic                       in_ready;
	logic signed [SAMPLE_W-1:0] sample = '0;
	logic                       last = 1'b0;
	logic                       out_valid;
	logic                       out_ready = 1'b0;
	logic [OUT_W-1:0]           rms_level;
	logic [OUT_W-1:0]           block_samples;
	logic                       too_long;

	block_rms_level #(
		.MAX_SAMPLES(MAX_SAMPLES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sample(sample),
		.last(last),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.rms_level(rms_level),
		.block_samples(block_samples),
		.too_long(too_long)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	audio_item_t sample_feed[$];
	rms_result_t rms_due[$];
	int          mismatches = 0;
	int          gap_left = 0;
	int          stall_left = 0;
	bit          steady_now = 1'b0;

	// running block state
	logic [46:0]      energy_sum = '0;
	logic [OUT_W-1:0] energy_count = '0;
	logic             energy_dropped = 1'b0;

	function automatic logic [OUT_W-1:0] floor_root(input logic [RAD_W-1:0] radicand);
		logic [OUT_W-1:0] root;
		logic [OUT_W-1:0] trial;
		longint unsigned  sq;
		root = '0;
		for (int b = OUT_W - 1; b >= 0; b--) begin
			trial = root | (OUT_W'(1) << b);
			sq = 64'(trial) * 64'(trial);
			if (sq <= 64'(radicand))
				root = trial;
		end
		return root;
	endfunction

	task automatic absorb_sample(input logic signed [SAMPLE_W-1:0] value, input logic closes);
		logic [SAMPLE_W:0]  mag;
		logic [48:0]        quad;
		logic [48:0]        quotient;
		rms_result_t        r;
		mag = value[SAMPLE_W-1] ? (17'h10000 - {1'b0, value}) : {1'b0, value};
		if (energy_count < MAX_SAMPLES) begin
			energy_sum = energy_sum + 47'(mag) * 47'(mag);
			energy_count = energy_count + 1'b1;
		end else begin
			energy_dropped = 1'b1;
		end
		if (closes) begin
			quad = {energy_sum, 2'b00};
			quotient = quad / 49'(energy_count);
			r.level = floor_root(RAD_W'(quotient));
			r.count = energy_count;
			r.clipped = energy_dropped;
			rms_due.push_back(r);
			energy_sum = '0;
			energy_count = '0;
			energy_dropped = 1'b0;
		end
	endtask

	function automatic void queue_item(input int value, input bit closes, input bit drain_first,
			input bit steady);
		audio_item_t it;
		it.value = SAMPLE_W'(value);
		it.closes = closes;
		it.drain_first = drain_first;
		it.steady = steady;
		sample_feed.push_back(it);
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(0, 7))
			0: return $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
			1, 2: return SAMPLE_W'($urandom_range(0, 64) - 32);
			default: return SAMPLE_W'($urandom());
		endcase
	endfunction

	always @(posedge clk) begin : drive
		audio_item_t                it;
		logic                       nxt_valid;
		logic signed [SAMPLE_W-1:0] nxt_sample;
		logic                       nxt_last;
		nxt_valid = in_valid;
		nxt_sample = sample;
		nxt_last = last;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				absorb_sample(sample, last);
				nxt_valid = 1'b0;
			end
			if (!nxt_valid) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (sample_feed.size() != 0 &&
						!(sample_feed[0].drain_first && rms_due.size() != 0)) begin
					it = sample_feed.pop_front();
					nxt_valid = 1'b1;
					nxt_sample = it.value;
					nxt_last = it.closes;
					steady_now <= it.steady;
					// gap opens once this item is taken
					if (!it.steady && $urandom_range(0, 99) < 10)
						gap_left = $urandom_range(1, 18);
				end
			end
		end
		in_valid <= nxt_valid;
		sample <= nxt_sample;
		last <= nxt_last;
	end

	always @(posedge clk) begin : observe
		rms_result_t want;
		logic        nxt_ready;
		nxt_ready = out_ready;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (rms_due.size() == 0) begin
					$error("unexpected result: rms_level %0d block_samples %0d too_long %0d",
						rms_level, block_samples, too_long);
					mismatches++;
				end else begin
					want = rms_due.pop_front();
					if (rms_level !== want.level) begin
						$error("rms_level: expected %0d, got %0d", want.level, rms_level);
						mismatches++;
					end
					if (block_samples !== want.count) begin
						$error("block_samples: expected %0d, got %0d", want.count,
							block_samples);
						mismatches++;
					end
					if (too_long !== want.clipped) begin
						$error("too_long: expected %0d, got %0d", want.clipped, too_long);
						mismatches++;
					end
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				nxt_ready = 1'b0;
			end else if (!steady_now && $urandom_range(0, 99) < 8) begin
				stall_left = $urandom_range(0, 17);
				nxt_ready = 1'b0;
			end else begin
				nxt_ready = 1'b1;
			end
		end
		out_ready <= nxt_ready;
	end

	initial begin : stimulus
		int total;
		int blen;
		int nblocks;

		// single-sample blocks at the extremes, then a two-sample full-scale block; negative full scale gives 65536
		queue_item(-32768, 1, 0, 0);
		queue_item(32767, 1, 0, 0);
		queue_item(0, 1, 0, 0);
		queue_item(-1, 1, 0, 0);
		queue_item(1, 1, 0, 0);
		queue_item(32767, 0, 0, 0);
		queue_item(-32768, 1, 0, 0);
		// alternating bit and byte patterns
		queue_item(16'h5555, 0, 0, 0);
		queue_item(16'hAAAA, 0, 0, 0);
		queue_item(16'h00FF, 0, 0, 0);
		queue_item(16'hFF00, 1, 0, 0);
		queue_item(0, 0, 0, 0);
		queue_item(0, 0, 0, 0);
		queue_item(-32768, 1, 0, 0);
		// hold until the pipeline drains, then send
		queue_item(12345, 1, 1, 0);
		queue_item(-12345, 0, 1, 0);
		queue_item(-2, 1, 0, 0);

		total = 0;
		nblocks = 0;
		while (total < RANDOM_ITEMS) begin
			case ($urandom_range(0, 9))
				0: blen = 1;
				1: blen = $urandom_range(50, 300);
				default: blen = $urandom_range(2, 16);
			endcase
			for (int i = 0; i < blen; i++)
				queue_item(pick_sample(), i == blen - 1, i == 0 && nblocks % 37 == 36,
					total + i >= CALM_FROM);
			total += blen;
			nblocks++;
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		@(negedge clk);
		while (sample_feed.size() != 0 || in_valid || rms_due.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);
		if (mismatches == 0)
			$display("block_rms_level regression: pass");
		else
			$display("block_rms_level regression: fail");
		$finish;
	end

	initial begin : watchdog
		#(15_000_000);
		$display("block_rms_level regression: fail");
		$finish;
	end

endmodule
